// ===== src/crcg_pkg.sv =====
package crcg_pkg;

   // operation bit meanings
   localparam int unsigned OpRodBit = 0;

   // pipeline depths
   localparam int unsigned SqrtCells = 33;
   localparam int unsigned DivCells  = 15;

   localparam logic [14:0] NormMax = 15'h7fff;

   // item as it travels through the front of the pipe
   typedef struct packed {
      logic        is_rod;
      logic        sx;
      logic        sy;
      logic [32:0] ax;
      logic [32:0] ay;
      logic [31:0] len;
      logic [15:0] bnc;
   } crcg_item_type;

   // one square-root cell's working set
   typedef struct packed {
      crcg_item_type item;
      logic [65:0]   rad;
      logic [35:0]   rem;
      logic [32:0]   root;
   } crcg_sq_type;

   // one divider cell's working set (both normal lanes)
   typedef struct packed {
      logic        is_rod;
      logic        contact;
      logic        compressed;
      logic        zero;
      logic        sat_x;
      logic        sat_y;
      logic        sx;
      logic        sy;
      logic [31:0] pen;
      logic [15:0] bnc;
      logic [32:0] span;
      logic [32:0] rem_x;
      logic [32:0] rem_y;
      logic [14:0] q_x;
      logic [14:0] q_y;
   } crcg_div_type;

endpackage

// ===== src/crcg_sqrt_cell.sv =====
module crcg_sqrt_cell
   import crcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  crcg_sq_type in_data,
   output logic        out_valid,
   output crcg_sq_type out_data
);

   logic        valid_ff;
   crcg_sq_type data_ff;
   crcg_sq_type data_in;
   logic [37:0] rem_sh;
   logic [37:0] trial;
   logic [37:0] diff;
   logic        ge;

   // resolve one root bit from the next radicand pair
   always_comb begin
      rem_sh  = {in_data.rem, in_data.rad[65:64]};
      trial   = {3'b000, in_data.root, 2'b01};
      ge      = rem_sh >= trial;
      diff    = rem_sh - trial;
      data_in = in_data;
      data_in.rad  = {in_data.rad[63:0], 2'b00};
      data_in.rem  = ge ? diff[35:0] : rem_sh[35:0];
      data_in.root = {in_data.root[31:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/crcg_div_cell.sv =====
module crcg_div_cell
   import crcg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  crcg_div_type in_data,
   output logic         out_valid,
   output crcg_div_type out_data
);

   logic         valid_ff;
   crcg_div_type data_ff;
   crcg_div_type data_in;
   logic [33:0]  sh_x;
   logic [33:0]  sh_y;
   logic [33:0]  dv;
   logic [33:0]  df_x;
   logic [33:0]  df_y;
   logic         ge_x;
   logic         ge_y;

   // take one quotient bit on each lane
   always_comb begin
      dv      = {1'b0, in_data.span};
      sh_x    = {in_data.rem_x, 1'b0};
      sh_y    = {in_data.rem_y, 1'b0};
      ge_x    = sh_x >= dv;
      ge_y    = sh_y >= dv;
      df_x    = sh_x - dv;
      df_y    = sh_y - dv;
      data_in = in_data;
      data_in.rem_x = ge_x ? df_x[32:0] : sh_x[32:0];
      data_in.rem_y = ge_y ? df_y[32:0] : sh_y[32:0];
      data_in.q_x   = {in_data.q_x[13:0], ge_x};
      data_in.q_y   = {in_data.q_y[13:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/cable_rod_contact_generator_core.sv =====
// Cable and rod contact generator: one beat in, one contact beat out, one
// beat per cycle sustained. Stages in order: input capture, square,
// sum, 33 square-root cells (one root bit each), a decision stage, 15
// divider cells (one normal bit per lane each) and the output register.
// The whole pipe moves together and stalls only while a finished result
// waits on rsp_ready.
module cable_rod_contact_generator_core
   import crcg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic [31:0]        req_rest_length,
   input  logic [15:0]        req_bounce,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_contact_valid,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [31:0]        rsp_penetration,
   output logic [15:0]        rsp_contact_bounce
);

   logic advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // capture differences as sign and magnitude
   logic [32:0]   dx;
   logic [32:0]   dy;
   crcg_item_type cap_in;
   crcg_item_type cap_ff;
   logic          cap_valid_ff;

   always_comb begin
      dx = {req_second_x[31], req_second_x} - {req_first_x[31], req_first_x};
      dy = {req_second_y[31], req_second_y} - {req_first_y[31], req_first_y};
      cap_in.is_rod = req_operation[OpRodBit];
      cap_in.sx     = dx[32];
      cap_in.sy     = dy[32];
      cap_in.ax     = dx[32] ? (~dx + 33'd1) : dx;
      cap_in.ay     = dy[32] ? (~dy + 33'd1) : dy;
      cap_in.len    = req_rest_length;
      cap_in.bnc    = req_bounce;
   end

   // square each magnitude; a magnitude of 2^32 has a zero low word
   logic [63:0]   prod_x;
   logic [63:0]   prod_y;
   logic [64:0]   sq_x_ff;
   logic [64:0]   sq_y_ff;
   crcg_item_type sq_item_ff;
   logic          sq_valid_ff;

   assign prod_x = cap_ff.ax[31:0] * cap_ff.ax[31:0];
   assign prod_y = cap_ff.ay[31:0] * cap_ff.ay[31:0];

   // sum of squares seeds the root chain
   crcg_sq_type sum_ff;
   logic        sum_valid_ff;
   logic [65:0] sum_in;

   assign sum_in = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         cap_valid_ff <= req_valid;
         sq_valid_ff  <= cap_valid_ff;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cap_ff          <= cap_in;
         sq_item_ff      <= cap_ff;
         sq_x_ff         <= cap_ff.ax[32] ? {1'b1, 64'd0} : {1'b0, prod_x};
         sq_y_ff         <= cap_ff.ay[32] ? {1'b1, 64'd0} : {1'b0, prod_y};
         sum_ff.item     <= sq_item_ff;
         sum_ff.rad      <= sum_in;
         sum_ff.rem      <= '0;
         sum_ff.root     <= '0;
      end
   end

   // square-root chain
   logic        sq_v [0:SqrtCells];
   crcg_sq_type sq_d [0:SqrtCells];

   assign sq_v[0] = sum_valid_ff;
   assign sq_d[0] = sum_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      crcg_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1])
      );
   end

   // decide contact, depth and normal saturation
   crcg_sq_type  root_s;
   crcg_div_type dec_in;
   crcg_div_type dec_ff;
   logic         dec_valid_ff;
   logic [32:0]  len33;
   logic [32:0]  pen33;
   logic         shorter;

   always_comb begin
      root_s  = sq_d[SqrtCells];
      len33   = {1'b0, root_s.item.len};
      shorter = root_s.root < len33;
      pen33   = shorter ? (len33 - root_s.root) : (root_s.root - len33);
      dec_in.is_rod     = root_s.item.is_rod;
      dec_in.contact    = root_s.item.is_rod ? (root_s.root != len33) : !shorter;
      dec_in.compressed = root_s.item.is_rod && shorter;
      dec_in.zero       = root_s.root == 33'd0;
      dec_in.sat_x      = root_s.item.ax >= root_s.root;
      dec_in.sat_y      = root_s.item.ay >= root_s.root;
      dec_in.sx         = root_s.item.sx;
      dec_in.sy         = root_s.item.sy;
      dec_in.pen        = pen33[32] ? 32'hffff_ffff : pen33[31:0];
      dec_in.bnc        = root_s.item.bnc;
      dec_in.span       = root_s.root;
      dec_in.rem_x      = root_s.item.ax;
      dec_in.rem_y      = root_s.item.ay;
      dec_in.q_x        = '0;
      dec_in.q_y        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= sq_v[SqrtCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
      end
   end

   // divider chain for the normal
   logic         dv_v [0:DivCells];
   crcg_div_type dv_d [0:DivCells];

   assign dv_v[0] = dec_valid_ff;
   assign dv_d[0] = dec_ff;

   for (genvar j = 0; j < DivCells; j++) begin : g_div
      crcg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_v[j]),
         .in_data   (dv_d[j]),
         .out_valid (dv_v[j+1]),
         .out_data  (dv_d[j+1])
      );
   end

   // apply sign, saturation and the no-contact zeroing
   crcg_div_type fin;
   logic [14:0]  mag_x;
   logic [14:0]  mag_y;
   logic [15:0]  nx;
   logic [15:0]  ny;
   logic         neg_x;
   logic         neg_y;

   always_comb begin
      fin   = dv_d[DivCells];
      mag_x = fin.zero ? 15'd0 : (fin.sat_x ? NormMax : fin.q_x);
      mag_y = fin.zero ? 15'd0 : (fin.sat_y ? NormMax : fin.q_y);
      neg_x = fin.sx ^ fin.compressed;
      neg_y = fin.sy ^ fin.compressed;
      nx    = neg_x ? (16'd0 - {1'b0, mag_x}) : {1'b0, mag_x};
      ny    = neg_y ? (16'd0 - {1'b0, mag_y}) : {1'b0, mag_y};
   end

   logic        out_valid_ff;
   logic        contact_ff;
   logic [15:0] nx_ff;
   logic [15:0] ny_ff;
   logic [31:0] pen_ff;
   logic [15:0] bnc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_v[DivCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         contact_ff <= fin.contact;
         nx_ff      <= fin.contact ? nx : 16'd0;
         ny_ff      <= fin.contact ? ny : 16'd0;
         pen_ff     <= fin.contact ? fin.pen : 32'd0;
         bnc_ff     <= (fin.contact && !fin.is_rod) ? fin.bnc : 16'd0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_contact_valid  = contact_ff;
   assign rsp_normal_x       = nx_ff;
   assign rsp_normal_y       = ny_ff;
   assign rsp_penetration    = pen_ff;
   assign rsp_contact_bounce = bnc_ff;

endmodule

// ===== sim/cable_rod_contact_generator_core_tb.sv =====
`timescale 1ns / 1ps

module cable_rod_contact_generator_core_tb;
   import crcg_pkg::*;

   // link kinds: bit 0 selects rod, bit 1 selects anchor
   localparam logic [1:0] KindCableLink   = 2'd0;
   localparam logic [1:0] KindRodLink     = 2'd1;
   localparam logic [1:0] KindCableAnchor = 2'd2;
   localparam logic [1:0] KindRodAnchor   = 2'd3;

   localparam int unsigned PipeDepth  = 53;
   localparam int unsigned StallLimit = 20000;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic [31:0]        len;
      logic [15:0]        bnc;
   } link_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [31:0]        pen;
      logic [15:0]        bnc;
   } contact_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = '0;
   logic signed [31:0] req_first_x = '0;
   logic signed [31:0] req_first_y = '0;
   logic signed [31:0] req_second_x = '0;
   logic signed [31:0] req_second_y = '0;
   logic [31:0]        req_rest_length = '0;
   logic [15:0]        req_bounce = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_contact_valid;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic [31:0]        rsp_penetration;
   logic [15:0]        rsp_contact_bounce;

   link_type    link_queue[$];
   contact_type contact_queue[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_cycles = 0;
   int unsigned quiet_cycles = 0;
   int unsigned errors = 0;
   int unsigned links_sent = 0;
   int unsigned contacts_seen = 0;
   int unsigned hits_seen = 0;
   bit          feed_done = 1'b0;

   cable_rod_contact_generator_core dut (.*);

   always #4 clock = ~clock;

   // floor square root of a value below 2^66
   function automatic logic [32:0] root_floor(logic [65:0] v);
      logic [32:0] r;
      logic [32:0] t;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         t = r | (33'd1 << b);
         if (67'(t) * 67'(t) <= 67'(v)) r = t;
      end
      return r;
   endfunction

   // signed Q1.15 component: truncated quotient, saturated, with sign of d
   function automatic logic signed [15:0] unit_comp(logic signed [33:0] d,
                                                    logic [32:0] span);
      logic [33:0] mag;
      logic [48:0] q;
      if (span == 0) return '0;
      mag = d < 0 ? -d : d;
      q = {mag, 15'd0} / 49'(span);
      if (q > 49'd32767) q = 49'd32767;
      return d < 0 ? -16'(q) : 16'(q);
   endfunction

   function automatic contact_type predict_contact(link_type l);
      contact_type c;
      logic signed [33:0] dx, dy;
      logic [33:0] mx, my;
      logic [32:0] span;
      logic [33:0] diff;
      logic rod, hit, squeezed;
      rod = l.kind[OpRodBit];
      dx = 34'(l.bx) - 34'(l.ax);
      dy = 34'(l.by) - 34'(l.ay);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      span = root_floor(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
      squeezed = rod && (span < 33'(l.len));
      hit = rod ? (span != 33'(l.len)) : (span >= 33'(l.len));
      c = '0;
      if (!hit) return c;
      diff = squeezed ? 34'(l.len) - 34'(span) : 34'(span) - 34'(l.len);
      c.hit = 1'b1;
      c.pen = diff > 34'hFFFFFFFF ? 32'hFFFFFFFF : diff[31:0];
      c.nx = unit_comp(dx, span);
      c.ny = unit_comp(dy, span);
      if (squeezed) begin
         c.nx = -c.nx;
         c.ny = -c.ny;
      end
      c.bnc = rod ? 16'd0 : l.bnc;
      return c;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
      endcase
   endfunction

   function automatic link_type rand_link();
      link_type l;
      logic [32:0] span;
      logic signed [33:0] dx, dy;
      l.kind = $urandom_range(0, 3);
      l.ax = rand_coord();
      l.ay = rand_coord();
      l.bx = rand_coord();
      l.by = rand_coord();
      l.bnc = $urandom();
      dx = 34'(l.bx) - 34'(l.ax);
      dy = 34'(l.by) - 34'(l.ay);
      span = root_floor(66'(dx < 0 ? -dx : dx) * 66'(dx < 0 ? -dx : dx)
                        + 66'(dy < 0 ? -dy : dy) * 66'(dy < 0 ? -dy : dy));
      // aim the length near the measured distance so both outcomes show
      case ($urandom_range(0, 4))
         0: l.len = $urandom();
         1: l.len = span[31:0];
         2: l.len = span[31:0] + 32'($urandom_range(0, 3)) - 32'd1;
         3: l.len = span[31:0] + 32'($urandom_range(0, 65536)) - 32'd32768;
         default: l.len = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0;
      endcase
      return l;
   endfunction

   function automatic link_type make_link(logic [1:0] k, int ax, int ay,
                                          int bx, int by, logic [31:0] len,
                                          logic [15:0] bnc);
      link_type l;
      l.kind = k; l.ax = ax; l.ay = ay; l.bx = bx; l.by = by;
      l.len = len; l.bnc = bnc;
      return l;
   endfunction

   // driver: hold the beat until accepted, then load the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (link_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            link_type l;
            l = link_queue.pop_front();
            req_valid <= 1'b1;
            req_operation <= l.kind;
            req_first_x <= l.ax;
            req_first_y <= l.ay;
            req_second_x <= l.bx;
            req_second_y <= l.by;
            req_rest_length <= l.len;
            req_bounce <= l.bnc;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // record expectation on each accepted beat
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         contact_queue.push_back(predict_contact({req_operation, req_first_x,
            req_first_y, req_second_x, req_second_y, req_rest_length,
            req_bounce}));
         links_sent++;
      end
   end

   // receiver backpressure, with a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         contact_type e;
         contacts_seen++;
         if (contact_queue.size() == 0) begin
            $display("%0t unexpected result beat", $time);
            errors++;
         end else begin
            e = contact_queue.pop_front();
            hits_seen += e.hit;
            if (rsp_contact_valid !== e.hit) begin
               $display("%0t contact_valid exp %0d got %0d", $time, e.hit,
                        rsp_contact_valid);
               errors++;
            end
            if (rsp_normal_x !== e.nx) begin
               $display("%0t normal_x exp %0d got %0d", $time, e.nx, rsp_normal_x);
               errors++;
            end
            if (rsp_normal_y !== e.ny) begin
               $display("%0t normal_y exp %0d got %0d", $time, e.ny, rsp_normal_y);
               errors++;
            end
            if (rsp_penetration !== e.pen) begin
               $display("%0t penetration exp %h got %h", $time, e.pen,
                        rsp_penetration);
               errors++;
            end
            if (rsp_contact_bounce !== e.bnc) begin
               $display("%0t contact_bounce exp %h got %h", $time, e.bnc,
                        rsp_contact_bounce);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset
          || feed_done)
         quiet_cycles <= 0;
      else if (link_queue.size() > 0 || contact_queue.size() > 0)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("%0t watchdog expired", $time);
         $display("** cable_rod_contact_generator_core: FAILED **");
         $finish;
      end
   end

   task automatic wait_drained();
      while (link_queue.size() > 0 || req_valid || contact_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every kind, zero length, extremes, exact fit, saturation
      link_queue.push_back(make_link(KindCableLink, 0, 0, 0, 0, 0, 16'hFFFF));
      link_queue.push_back(make_link(KindRodLink, 0, 0, 0, 0, 0, 16'h1234));
      link_queue.push_back(make_link(KindCableAnchor, 5, 5, 5, 5, 1, 16'hABCD));
      link_queue.push_back(make_link(KindRodAnchor, 7, 7, 7, 7, 32'h10000, 16'h1));
      link_queue.push_back(make_link(KindCableLink, 0, 0, 32'h30000, 32'h40000,
                                     32'h50000, 16'h8000));
      link_queue.push_back(make_link(KindCableLink, 0, 0, 32'h30000, 32'h40000,
                                     32'h50001, 16'h8000));
      link_queue.push_back(make_link(KindRodLink, 0, 0, 32'h30000, 32'h40000,
                                     32'h50000, 16'h8000));
      link_queue.push_back(make_link(KindRodLink, 0, 0, 32'h30000, 32'h40000,
                                     32'hA0000, 16'h8000));
      link_queue.push_back(make_link(KindRodAnchor, 0, 0, -32'h30000, -32'h40000,
                                     32'h10000, 16'h0));
      link_queue.push_back(make_link(KindCableLink, 32'h80000000, 32'h80000000,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 0, 16'hFFFF));
      link_queue.push_back(make_link(KindCableAnchor, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h80000000, 32'h80000000, 32'hFFFFFFFF, 16'h5555));
      link_queue.push_back(make_link(KindRodLink, 32'h80000000, 0, 32'h7FFFFFFF, 0,
                                     0, 16'hFFFF));
      link_queue.push_back(make_link(KindRodAnchor, 0, 0, 1, 0, 32'hFFFFFFFF, 16'h0));
      link_queue.push_back(make_link(KindCableLink, 0, 0, 0, -32'h10000, 0, 16'h7));
      link_queue.push_back(make_link(KindRodLink, 0, 0, -1, 1, 0, 16'h7));
      link_queue.push_back(make_link(KindCableAnchor, -1, -1, 0, 0, 0, 16'hAAAA));
      wait_drained();

      // random phases: free run, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 37 : 0;
         recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 37 : 0;
         for (int i = 0; i < 400; i++) link_queue.push_back(rand_link());
         if (ph == 0) hold_cycles = 300;
         wait_drained();
      end

      // free run again with one long receiver hold-off
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 400; i++) link_queue.push_back(rand_link());
      hold_cycles = 200;
      wait_drained();

      repeat (PipeDepth + 10) @(posedge clock);
      feed_done = 1'b1;
      $display("covered %0d links (all four kinds, extremes, zero length), %0d with contact",
               links_sent, hits_seen);
      $display("idle/stall phases and long receiver hold-off exercised");
      if (errors == 0 && contact_queue.size() == 0)
         $display("** cable_rod_contact_generator_core: PASSED **");
      else
         $display("** cable_rod_contact_generator_core: FAILED **");
      $finish;
   end

endmodule
